// ===== hdl/cpt_pkg.sv =====
// package: region codes and result field sizes shared by the closest point block
`default_nettype none
package cpt_pkg;

	localparam int REGION_W = 3;
	localparam int USER_W   = REGION_W + 1;

	typedef enum logic [REGION_W-1:0] {
		REG_A  = 3'd0,
		REG_B  = 3'd1,
		REG_C  = 3'd2,
		REG_AB = 3'd3,
		REG_AC = 3'd4,
		REG_BC = 3'd5,
		REG_IN = 3'd6
	} region_t;

endpackage
`default_nettype wire

// ===== hdl/cpt_mul.sv =====
// module: signed multiplier split into four registered partial products, then a registered sum
`default_nettype none
module cpt_mul #(
	parameter int DW = 68
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic signed [DW-1:0]   a,
	input  wire logic signed [DW-1:0]   b,
	output logic signed [2*DW-1:0]      p
);

	localparam int L  = DW / 2;
	localparam int H  = DW - L;
	localparam int MW = 2 * DW;

	logic signed [H-1:0]     ah, bh;
	logic signed [L:0]       al, bl;
	logic signed [2*H-1:0]   hh_s1;
	logic signed [H+L:0]     hl_s1, lh_s1;
	logic signed [2*L+1:0]   ll_s1;

	// high halves carry the sign, low halves are zero-extended
	assign ah = a[DW-1:L];
	assign bh = b[DW-1:L];
	assign al = {1'b0, a[L-1:0]};
	assign bl = {1'b0, b[L-1:0]};

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * bl;
			lh_s1 <= al * bh;
			ll_s1 <= al * bl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (MW'(hh_s1) <<< (2 * L)) + (MW'(hl_s1) <<< L) + (MW'(lh_s1) <<< L)
				+ MW'(ll_s1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cpt_div.sv =====
// module: pipelined restoring divider, two numerators over one shared divisor
`default_nettype none
module cpt_div #(
	parameter int NW = 139,
	parameter int FB = 16,
	parameter int QB = 18,
	parameter int PW = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [NW-1:0] num0,
	input  wire logic signed [NW-1:0] num1,
	input  wire logic signed [NW-1:0] den,
	input  wire logic [PW-1:0]        in_pay,
	output logic                      out_valid,
	output logic signed [QB:0]        q0,
	output logic signed [QB:0]        q1,
	output logic [PW-1:0]             out_pay
);

	localparam int RW = NW + FB + QB;

	logic [NW-1:0] den_s  [QB];
	logic [RW-1:0] rem0_s [QB];
	logic [RW-1:0] rem1_s [QB];
	logic [QB-1:0] quo0_s [QB+1];
	logic [QB-1:0] quo1_s [QB+1];
	logic          neg0_s [QB+1];
	logic          neg1_s [QB+1];
	logic          vld_s  [QB+1];
	logic [PW-1:0] pay_s  [QB+1];

	logic [NW-1:0]     n0m, n1m, dm;
	logic signed [QB:0] qm0, qm1;

	// magnitudes; quotient sign is fixed up at the end
	always_comb begin
		n0m = num0[NW-1] ? NW'(-num0) : num0;
		n1m = num1[NW-1] ? NW'(-num1) : num1;
		dm  = den[NW-1]  ? NW'(-den)  : den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= dm;
			rem0_s[0] <= RW'(n0m) << FB;
			rem1_s[0] <= RW'(n1m) << FB;
			quo0_s[0] <= '0;
			quo1_s[0] <= '0;
			neg0_s[0] <= num0[NW-1] ^ den[NW-1];
			neg1_s[0] <= num1[NW-1] ^ den[NW-1];
			pay_s[0]  <= in_pay;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= QB; j++) begin : g_stage
		logic [RW-1:0] trial;
		logic          ge0, ge1;

		assign trial = RW'(den_s[j-1]) << (QB - j);
		assign ge0   = rem0_s[j-1] >= trial;
		assign ge1   = rem1_s[j-1] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo0_s[j] <= {quo0_s[j-1][QB-2:0], ge0};
				quo1_s[j] <= {quo1_s[j-1][QB-2:0], ge1};
				neg0_s[j] <= neg0_s[j-1];
				neg1_s[j] <= neg1_s[j-1];
				pay_s[j]  <= pay_s[j-1];
			end
		end

		if (j < QB) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[j]  <= den_s[j-1];
					rem0_s[j] <= ge0 ? rem0_s[j-1] - trial : rem0_s[j-1];
					rem1_s[j] <= ge1 ? rem1_s[j-1] - trial : rem1_s[j-1];
				end
			end
		end
	end

	assign qm0       = {1'b0, quo0_s[QB]};
	assign qm1       = {1'b0, quo1_s[QB]};
	assign q0        = neg0_s[QB] ? -qm0 : qm0;
	assign q1        = neg1_s[QB] ? -qm1 : qm1;
	assign out_valid = vld_s[QB];
	assign out_pay   = pay_s[QB];

endmodule
`default_nettype wire

// ===== hdl/closest_point_on_triangle.sv =====
// top level: pipelined closest point on a triangle to a query point
//
// usage
//   input stream  s_tvalid/s_tready/s_tdata: one request per query, twelve signed
//     fixed-point coordinates (query, vertex a, b, c; x y z each), COORD_BITS wide
//     with FRAC_BITS fraction bits
//   output stream m_tvalid/m_tready/m_tdata/m_tuser: one result per request, the
//     nearest point in tdata and the chosen region and zero-divisor flag in tuser
//   divider: one quotient bit per stage
//   throughput: one request per cycle unless the output stalls, with earlier
//     requests still in flight
//   stall: every stage shares one enable; while a result sits unaccepted in the
//     output register the whole pipe freezes and s_tready drops, nothing is lost
//   reset: arst_n clears all valid bits; data registers are left alone
//   region tests use exact products (dot terms, then cross terms through split
//     multipliers); only the final weights and weighted edges are truncated
//   a zero divisor returns vertex a with the degenerate flag set
`default_nettype none
module closest_point_on_triangle
	import cpt_pkg::*;
#(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// query_x, query_y, query_z, vert_a_x .. vert_a_z, vert_b_x .. vert_b_z,
	// vert_c_x .. vert_c_z, each COORD_BITS, lowest first
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic [((12*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// near_x, near_y, near_z, each COORD_BITS, lowest first
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [((3*COORD_BITS+7)/8)*8-1:0]          m_tdata,
	// region [2:0], degenerate [3]
	output logic [USER_W-1:0]                          m_tuser
);

	localparam int CB  = COORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int EW  = CB + 1;          // coordinate differences
	localparam int DW  = 2 * CB + 4;      // dot products
	localparam int MW  = 2 * DW;          // cross products
	localparam int VW  = 4 * CB + 11;     // cross differences and their sum
	localparam int QB  = F + 2;           // quotient magnitude bits
	localparam int QW  = QB + 1;
	localparam int SPW = QW + EW;         // weight times edge
	localparam int SW  = SPW - F;
	localparam int UW  = SW + 2;          // base plus two scaled edges

	localparam logic [SPW-1:0] RND = SPW'((64'd1 << F) - 64'd1);

	typedef logic signed [CB-1:0] crd_t;
	typedef logic signed [EW-1:0] dif_t;
	typedef logic signed [DW-1:0] dot_t;
	typedef logic signed [MW-1:0] mul_t;
	typedef logic signed [VW-1:0] wide_t;

	typedef struct packed {
		crd_t [2:0] a;
		crd_t [2:0] b;
		crd_t [2:0] c;
		dif_t [2:0] ab;
		dif_t [2:0] ac;
		dif_t [2:0] bc;
	} geo_t;

	typedef struct packed {
		crd_t [2:0] base;
		dif_t [2:0] e0;
		dif_t [2:0] e1;
		region_t    region;
		logic       degen;
		logic       use_div;
	} pay_t;

	localparam int PW = $bits(pay_t);

	// cross term operands: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6, va = d3*d6 - d5*d4
	localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
	localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

	logic adv;

	// ---------------------------------------------------------------- stage 1
	crd_t p_in [3], a_in [3], b_in [3], c_in [3];
	geo_t geo_n, geo_s1, geo_s2, geo_s3, geo_s4, geo_s5;
	dif_t ap_s1 [3], bp_s1 [3], cp_s1 [3];
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, vo_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			p_in[k]     = s_tdata[k*CB +: CB];
			a_in[k]     = s_tdata[(3+k)*CB +: CB];
			b_in[k]     = s_tdata[(6+k)*CB +: CB];
			c_in[k]     = s_tdata[(9+k)*CB +: CB];
			geo_n.a[k]  = a_in[k];
			geo_n.b[k]  = b_in[k];
			geo_n.c[k]  = c_in[k];
			geo_n.ab[k] = EW'(b_in[k]) - EW'(a_in[k]);
			geo_n.ac[k] = EW'(c_in[k]) - EW'(a_in[k]);
			geo_n.bc[k] = EW'(c_in[k]) - EW'(b_in[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= geo_n;
			for (int k = 0; k < 3; k++) begin
				ap_s1[k] <= EW'(p_in[k]) - EW'(a_in[k]);
				bp_s1[k] <= EW'(p_in[k]) - EW'(b_in[k]);
				cp_s1[k] <= EW'(p_in[k]) - EW'(c_in[k]);
			end
		end
	end

	// ---------------------------------------------------------------- stage 2
	// d1 ab.ap, d2 ac.ap, d3 ab.bp, d4 ac.bp, d5 ab.cp, d6 ac.cp
	dif_t dx [6][3], dy [6][3];
	logic signed [2*EW-1:0] pr_s2 [6][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dx[0][k] = geo_s1.ab[k]; dy[0][k] = ap_s1[k];
			dx[1][k] = geo_s1.ac[k]; dy[1][k] = ap_s1[k];
			dx[2][k] = geo_s1.ab[k]; dy[2][k] = bp_s1[k];
			dx[3][k] = geo_s1.ac[k]; dy[3][k] = bp_s1[k];
			dx[4][k] = geo_s1.ab[k]; dy[4][k] = cp_s1[k];
			dx[5][k] = geo_s1.ac[k]; dy[5][k] = cp_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s2 <= geo_s1;
			for (int i = 0; i < 6; i++) begin
				for (int k = 0; k < 3; k++) begin
					pr_s2[i][k] <= dx[i][k] * dy[i][k];
				end
			end
		end
	end

	// ---------------------------------------------------------------- stage 3
	dot_t dd_s3 [6], dd_s4 [6], dd_s5 [6];

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s3 <= geo_s2;
			for (int i = 0; i < 6; i++) begin
				dd_s3[i] <= DW'(pr_s2[i][0]) + DW'(pr_s2[i][1]) + DW'(pr_s2[i][2]);
			end
		end
	end

	// ---------------------------------------------------------- stages 4 and 5
	mul_t mp_s5 [6];

	for (genvar i = 0; i < 6; i++) begin : g_cross
		cpt_mul #(.DW(DW)) u_mul (
			.clk (clk),
			.en  (adv),
			.a   (dd_s3[MA[i]]),
			.b   (dd_s3[MB[i]]),
			.p   (mp_s5[i])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s4 <= geo_s3;
			geo_s5 <= geo_s4;
			dd_s4  <= dd_s3;
			dd_s5  <= dd_s4;
		end
	end

	// ---------------------------------------------------------------- stage 6
	// region tests in the classic order, then divisor and weight selection
	wide_t d [6];
	wide_t va, vb, vc, dsum, d43, d56;
	wide_t num0_n, num1_n, den_n, num0_s6, num1_s6, den_s6;
	pay_t  pay_n, pay_s6;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			d[i] = VW'(dd_s5[i]);
		end
		vc   = VW'(mp_s5[0]) - VW'(mp_s5[1]);
		vb   = VW'(mp_s5[2]) - VW'(mp_s5[3]);
		va   = VW'(mp_s5[4]) - VW'(mp_s5[5]);
		dsum = va + vb + vc;
		d43  = d[3] - d[2];
		d56  = d[4] - d[5];

		pay_n.base    = geo_s5.a;
		pay_n.e0      = '0;
		pay_n.e1      = '0;
		pay_n.region  = REG_A;
		pay_n.degen   = 1'b0;
		pay_n.use_div = 1'b0;
		num0_n        = '0;
		num1_n        = '0;
		den_n         = '0;

		if (d[0] <= 0 && d[1] <= 0) begin
			pay_n.region = REG_A;
		end else if (d[2] >= 0 && d[3] <= d[2]) begin
			pay_n.region = REG_B;
			pay_n.base   = geo_s5.b;
		end else if (vc <= 0 && d[0] >= 0 && d[2] <= 0) begin
			pay_n.region  = REG_AB;
			pay_n.e0      = geo_s5.ab;
			pay_n.use_div = 1'b1;
			num0_n        = d[0];
			den_n         = d[0] - d[2];
		end else if (d[5] >= 0 && d[4] <= d[5]) begin
			pay_n.region = REG_C;
			pay_n.base   = geo_s5.c;
		end else if (vb <= 0 && d[1] >= 0 && d[5] <= 0) begin
			pay_n.region  = REG_AC;
			pay_n.e0      = geo_s5.ac;
			pay_n.use_div = 1'b1;
			num0_n        = d[1];
			den_n         = d[1] - d[5];
		end else if (va <= 0 && d43 >= 0 && d56 >= 0) begin
			pay_n.region  = REG_BC;
			pay_n.base    = geo_s5.b;
			pay_n.e0      = geo_s5.bc;
			pay_n.use_div = 1'b1;
			num0_n        = d43;
			den_n         = d43 + d56;
		end else begin
			pay_n.region  = REG_IN;
			pay_n.e0      = geo_s5.ab;
			pay_n.e1      = geo_s5.ac;
			pay_n.use_div = 1'b1;
			num0_n        = vb;
			num1_n        = vc;
			den_n         = dsum;
		end

		// zero divisor: vertex a, region kept
		if (pay_n.use_div && den_n == 0) begin
			pay_n.degen   = 1'b1;
			pay_n.use_div = 1'b0;
			pay_n.base    = geo_s5.a;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num0_s6 <= num0_n;
			num1_s6 <= num1_n;
			den_s6  <= den_n;
			pay_s6  <= pay_n;
		end
	end

	// ---------------------------------------------------------------- divider
	logic              v_d;
	logic signed [QB:0] q0_d, q1_d;
	pay_t              pay_d;

	cpt_div #(.NW(VW), .FB(F), .QB(QB), .PW(PW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s6),
		.num0      (num0_s6),
		.num1      (num1_s6),
		.den       (den_s6),
		.in_pay    (pay_s6),
		.out_valid (v_d),
		.q0        (q0_d),
		.q1        (q1_d),
		.out_pay   (pay_d)
	);

	// ---------------------------------------------------------------- stage 7
	dif_t    e0c [3], e1c [3];
	logic signed [SPW-1:0] sp0_s7 [3], sp1_s7 [3];
	crd_t    base_s7 [3];
	region_t region_s7;
	logic    degen_s7;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e0c[k] = pay_d.e0[k];
			e1c[k] = pay_d.e1[k];
		end
	end

	// signed zero keeps the products signed
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				sp0_s7[k]  <= pay_d.use_div ? q0_d * e0c[k] : SPW'(0);
				sp1_s7[k]  <= pay_d.use_div ? q1_d * e1c[k] : SPW'(0);
				base_s7[k] <= pay_d.base[k];
			end
			region_s7 <= pay_d.region;
			degen_s7  <= pay_d.degen;
		end
	end

	// ---------------------------------------------------------- output stage
	// truncate toward zero, add to base, saturate
	logic [SPW-1:0]        adj0 [3], adj1 [3];
	logic signed [SW-1:0]  t0 [3], t1 [3];
	logic signed [UW-1:0]  sum [3];
	logic [UW-CB:0]        hi [3];
	crd_t                  res [3], near_q [3];
	region_t               region_q;
	logic                  degen_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			adj0[k] = sp0_s7[k] + (sp0_s7[k][SPW-1] ? RND : '0);
			adj1[k] = sp1_s7[k] + (sp1_s7[k][SPW-1] ? RND : '0);
			t0[k]   = adj0[k][SPW-1:F];
			t1[k]   = adj1[k][SPW-1:F];
			sum[k]  = UW'(base_s7[k]) + UW'(t0[k]) + UW'(t1[k]);
			hi[k]   = sum[k][UW-1:CB-1];
			if (&hi[k] || ~|hi[k]) begin
				res[k] = sum[k][CB-1:0];
			end else if (sum[k][UW-1]) begin
				res[k] = {1'b1, {(CB-1){1'b0}}};
			end else begin
				res[k] = {1'b0, {(CB-1){1'b1}}};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			near_q   <= res;
			region_q <= region_s7;
			degen_q  <= degen_s7;
		end
	end

	// ---------------------------------------------------------- valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			vo_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_d;
			vo_q <= v_s7;
		end
	end

	// whole pipe moves unless a result is waiting on a stalled receiver
	assign adv      = !vo_q || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vo_q;
	assign m_tuser  = {degen_q, region_q};

	always_comb begin
		m_tdata = '0;
		for (int k = 0; k < 3; k++) begin
			m_tdata[k*CB +: CB] = near_q[k];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cpt_chk.sv =====
// checker: port-level assertions for the closest point block, with its bind
`default_nettype none
module cpt_chk
	import cpt_pkg::*;
#(
	parameter int OW = 96
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tvalid,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OW-1:0]     m_tdata,
	input wire logic [USER_W-1:0] m_tuser
);

	region_t reg_out;
	logic    in_req;

	assign reg_out = region_t'(m_tuser[REGION_W-1:0]);
	assign in_req  = s_tvalid && s_tready;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// degenerate only comes from a region that divides
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[REGION_W] |->
			reg_out == REG_AB || reg_out == REG_AC || reg_out == REG_BC || reg_out == REG_IN)
		else $error("degenerate flag on a vertex region");

	// empty output register never blocks intake
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// a stalled receiver freezes intake
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !in_req)
		else $error("request taken while output stalled");

endmodule

bind closest_point_on_triangle cpt_chk #(
	.OW(((3*COORD_BITS+7)/8)*8)
) u_cpt_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the closest point on triangle block: directed table, then random queries
module tb;
	import cpt_pkg::*;

	localparam int COORD_BITS = 32;
	localparam int FRAC_BITS  = 16;
	localparam int N_RANDOM   = 1450;
	localparam int IDLE_LIMIT = 5000;

	typedef logic signed [255:0] wide_t;
	typedef logic [12*COORD_BITS-1:0] query_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] z;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] x;
		logic                  degenerate;
		region_t               region;
	} near_t;

	typedef struct {
		query_t q;
		bit     known;
		near_t  want;
	} row_t;

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [12*COORD_BITS-1:0] s_tdata;
	logic [3*COORD_BITS-1:0]  m_tdata;
	logic [USER_W-1:0]        m_tuser;

	near_t pending[$];
	int    errors = 0;
	int    accepted = 0;
	int    idle = 0;

	closest_point_on_triangle uut (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic wide_t sx(logic [COORD_BITS-1:0] v);
		return wide_t'($signed(v));
	endfunction

	// weight num/den in Q.F, then applied to one edge component
	function automatic wide_t weighted(wide_t num, wide_t den, wide_t e);
		wide_t t;
		t = (num * (wide_t'(1) <<< FRAC_BITS)) / den;
		return (t * e) / (wide_t'(1) <<< FRAC_BITS);
	endfunction

	function automatic logic [COORD_BITS-1:0] clamp(wide_t v);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (COORD_BITS-1)) - 1;
		lo = -(wide_t'(1) <<< (COORD_BITS-1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic near_t pack_near(wide_t px, wide_t py, wide_t pz, region_t r, bit dg);
		near_t n;
		n.x = clamp(px);
		n.y = clamp(py);
		n.z = clamp(pz);
		n.region = r;
		n.degenerate = dg;
		return n;
	endfunction

	function automatic wide_t dot3(wide_t u[3], wide_t v[3]);
		return u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
	endfunction

	// voronoi region walk on exact products
	function automatic near_t closest_point(query_t q);
		wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
		wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, den, num;
		for (int k = 0; k < 3; k++) begin
			p[k] = sx(q[k*COORD_BITS +: COORD_BITS]);
			a[k] = sx(q[(k+3)*COORD_BITS +: COORD_BITS]);
			b[k] = sx(q[(k+6)*COORD_BITS +: COORD_BITS]);
			c[k] = sx(q[(k+9)*COORD_BITS +: COORD_BITS]);
			ab[k] = b[k] - a[k];
			ac[k] = c[k] - a[k];
			ap[k] = p[k] - a[k];
			bp[k] = p[k] - b[k];
			cp[k] = p[k] - c[k];
			bc[k] = c[k] - b[k];
		end
		d1 = dot3(ab, ap);
		d2 = dot3(ac, ap);
		if (d1 <= 0 && d2 <= 0) return pack_near(a[0], a[1], a[2], REG_A, 0);
		d3 = dot3(ab, bp);
		d4 = dot3(ac, bp);
		if (d3 >= 0 && d4 <= d3) return pack_near(b[0], b[1], b[2], REG_B, 0);
		vc = d1*d4 - d3*d2;
		if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			den = d1 - d3;
			if (den == 0) return pack_near(a[0], a[1], a[2], REG_AB, 1);
			return pack_near(a[0] + weighted(d1, den, ab[0]), a[1] + weighted(d1, den, ab[1]),
				a[2] + weighted(d1, den, ab[2]), REG_AB, 0);
		end
		d5 = dot3(ab, cp);
		d6 = dot3(ac, cp);
		if (d6 >= 0 && d5 <= d6) return pack_near(c[0], c[1], c[2], REG_C, 0);
		vb = d5*d2 - d1*d6;
		if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			den = d2 - d6;
			if (den == 0) return pack_near(a[0], a[1], a[2], REG_AC, 1);
			return pack_near(a[0] + weighted(d2, den, ac[0]), a[1] + weighted(d2, den, ac[1]),
				a[2] + weighted(d2, den, ac[2]), REG_AC, 0);
		end
		va = d3*d6 - d5*d4;
		if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
			num = d4 - d3;
			den = num + (d5 - d6);
			if (den == 0) return pack_near(a[0], a[1], a[2], REG_BC, 1);
			return pack_near(b[0] + weighted(num, den, bc[0]), b[1] + weighted(num, den, bc[1]),
				b[2] + weighted(num, den, bc[2]), REG_BC, 0);
		end
		den = va + vb + vc;
		if (den == 0) return pack_near(a[0], a[1], a[2], REG_IN, 1);
		return pack_near(
			a[0] + weighted(vb, den, ab[0]) + weighted(vc, den, ac[0]),
			a[1] + weighted(vb, den, ab[1]) + weighted(vc, den, ac[1]),
			a[2] + weighted(vb, den, ab[2]) + weighted(vc, den, ac[2]), REG_IN, 0);
	endfunction

	function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
		int bx, int by, int bz, int cx, int cy, int cz);
		return {cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px};
	endfunction

	function automatic int coord(int span);
		return int'($urandom_range(2*span)) - span;
	endfunction

	// random query: mostly small well-formed triangles, some full range and collapsed ones
	function automatic query_t random_query();
		int v[12];
		int kind, span, s;
		kind = $urandom_range(99);
		span = (kind < 10) ? 4 : (kind < 70) ? (1 << $urandom_range(20, 8)) : 32'h7fffffff;
		foreach (v[i]) v[i] = (span == 32'h7fffffff) ? int'($urandom) : coord(span);
		if (kind >= 85 && kind < 92) begin
			// b on a
			v[6] = v[3]; v[7] = v[4]; v[8] = v[5];
		end else if (kind >= 92) begin
			// c on line ab
			s = coord(3);
			for (int k = 0; k < 3; k++) v[9+k] = v[3+k] + s * (v[6+k] - v[3+k]);
			if (kind >= 97) for (int k = 0; k < 9; k++) v[3+k] = v[3 + k % 3];
		end
		return {v[11], v[10], v[9], v[8], v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
	endfunction

	task automatic report(string what, logic [127:0] got, logic [127:0] want);
		errors++;
		$display("mismatch on %s: got %h, expected %h", what, got, want);
	endtask

	// handshakes are sampled at the falling edge and take effect at the next rising edge
	always @(negedge clk) begin
		near_t want;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				report("unexpected result", {m_tuser, m_tdata}, 0);
			end else begin
				want = pending.pop_front();
				if (m_tdata[0 +: COORD_BITS] !== want.x) report("near_x", m_tdata[0 +: 32], want.x);
				if (m_tdata[32 +: COORD_BITS] !== want.y) report("near_y", m_tdata[32 +: 32], want.y);
				if (m_tdata[64 +: COORD_BITS] !== want.z) report("near_z", m_tdata[64 +: 32], want.z);
				if (m_tuser[REGION_W-1:0] !== want.region) report("region", m_tuser, want.region);
				if (m_tuser[REGION_W] !== want.degenerate) report("degenerate", m_tuser, want.degenerate);
			end
		end
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) idle++;
		else idle = 0;
		if (idle >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off to back the pipe up
	initial begin
		int hold;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (accepted == 300 && hold == 0) begin
				m_tready <= 0;
				hold = 1;
				repeat (150) @(posedge clk);
			end else begin
				case ((accepted / 97) % 3)
					0: m_tready <= 1;
					1: m_tready <= ($urandom_range(3) != 0);
					default: m_tready <= ($urandom_range(2) == 0);
				endcase
			end
		end
	end

	task automatic send(query_t q, bit known, near_t want);
		near_t model;
		s_tdata  <= q;
		s_tvalid <= 1;
		do @(negedge clk); while (!s_tready);
		model = closest_point(q);
		if (known && model !== want) report("table entry", model, want);
		pending = {pending, (known ? want : model)};
		accepted++;
		@(posedge clk);
	endtask

	initial begin
		row_t  table_rows[$];
		row_t  r;
		int    burst, gap;
		localparam int ONE = 1 << FRAC_BITS;
		s_tvalid = 0;
		s_tdata  = '0;
		arst_n   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// triangle a=(0,0,0) b=(1,0,0) c=(0,1,0)
		r.known = 1;
		r.q = make_query(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		r.want = pack_near(0, 0, 0, REG_A, 0); table_rows = {table_rows, r};
		r.q = make_query(2*ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		r.want = pack_near(ONE, 0, 0, REG_B, 0); table_rows = {table_rows, r};
		r.q = make_query(-ONE, 2*ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		r.want = pack_near(0, ONE, 0, REG_C, 0); table_rows = {table_rows, r};
		r.q = make_query(ONE/2, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		r.want = pack_near(ONE/2, 0, 0, REG_AB, 0); table_rows = {table_rows, r};
		r.q = make_query(-ONE, ONE/2, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		r.want = pack_near(0, ONE/2, 0, REG_AC, 0); table_rows = {table_rows, r};
		r.q = '0;
		r.want = pack_near(0, 0, 0, REG_A, 0); table_rows = {table_rows, r};
		r.known = 0;
		r.q = make_query(ONE, ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0); table_rows = {table_rows, r};
		r.q = make_query(ONE/4, ONE/4, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0);
		table_rows = {table_rows, r};
		r.q = make_query(3, 5, -7, 0, 0, 0, 10, 1, 2, -3, 11, 4); table_rows = {table_rows, r};
		// collinear and collapsed triangles
		r.q = make_query(ONE, ONE, ONE, 0, 0, 0, ONE, 0, 0, 2*ONE, 0, 0);
		table_rows = {table_rows, r};
		r.q = make_query(0, ONE, 0, 0, 0, 0, ONE, 0, 0, -ONE, 0, 0); table_rows = {table_rows, r};
		r.q = make_query(ONE, ONE, 0, 5, 5, 5, 5, 5, 5, 5, 5, 5); table_rows = {table_rows, r};
		// extremes and saturation
		r.q = {12{32'h7fffffff}}; table_rows = {table_rows, r};
		r.q = {12{32'h80000000}}; table_rows = {table_rows, r};
		r.q = make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			0, 32'h7fffffff, 32'h80000000, 0, 32'h80000000, 32'h7fffffff, 0);
		table_rows = {table_rows, r};
		r.q = make_query(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		table_rows = {table_rows, r};
		r.q = make_query(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7fffffff);
		table_rows = {table_rows, r};

		foreach (table_rows[i]) send(table_rows[i].q, table_rows[i].known, table_rows[i].want);

		burst = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			if (burst == 0) begin
				burst = $urandom_range(40, 1);
				gap = (n > 1000 && n < 1150) ? 0 : $urandom_range(6);
				if (gap > 0) begin
					s_tvalid <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			r.known = 0;
			send(random_query(), 0, r.want);
		end
		s_tvalid <= 0;

		wait (pending.size() == 0);
		repeat (2 * FRAC_BITS + 20) @(posedge clk);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/cpt_pkg.sv
hdl/cpt_mul.sv
hdl/cpt_div.sv
hdl/closest_point_on_triangle.sv
hdl/cpt_chk.sv
sim/tb.sv
